// ----- src/rcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_pkg
// Types and codes shared by the record chain scanner: result word layout,
// record kinds, failure codes and header byte constants.
// ---------------------------------------------------------------------------
package rcs_pkg;

	// record kinds
	localparam logic [1:0] KIND_MEMBER   = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_FAILURE  = 2'd2;

	// failure codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NOT_EXE    = 3'd1;
	localparam logic [2:0] ERR_TOO_SMALL  = 3'd2;
	localparam logic [2:0] ERR_NO_CHAIN   = 3'd3;
	localparam logic [2:0] ERR_MEMBERS    = 3'd4;
	localparam logic [2:0] ERR_PROBES     = 3'd5;
	localparam logic [2:0] ERR_CANDIDATES = 3'd6;

	// header classification
	typedef enum logic [1:0] {
		HDR_INVALID,
		HDR_MEMBER,
		HDR_END
	} hdr_kind_t;

	// header bytes
	localparam logic [7:0] TAG_B0   = 8'h41;
	localparam logic [7:0] TAG_B1   = 8'h52;
	localparam logic [7:0] TAG_B2   = 8'h4E;
	localparam logic [7:0] TAG_B3   = 8'h49;
	localparam logic [7:0] NG_LO    = 8'h4E;
	localparam logic [7:0] NG_HI    = 8'h47;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_M   = 8'h4D;
	localparam logic [7:0] CHAR_Z   = 8'h5A;

	localparam int WIN_HIST = 9;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] header_offset;
		logic [31:0] packed_size;
		logic [23:0] unpacked_size;
		logic [31:0] chain_end;
		logic [2:0]  error_code;
		logic        run_end;
	} result_t;

endpackage
`default_nettype wire

// ----- src/record_chain_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// record_chain_scanner
// Streaming locator of a tagged record chain inside a carrier file.
// ---------------------------------------------------------------------------
// Usage:
//   Write carrier_size on the cfg channel (cfg_valid/cfg_ready/cfg_data)
//   before the first byte. Feed the carrier one byte per word on the input
//   channel (in_valid/in_ready), is_last_byte set on its final byte.
//   Each result word (member, chain complete or failure) leaves on the
//   output channel (out_valid/out_ready); run_end marks the last result
//   caused by one byte.
//   Throughput: one byte per cycle while in_ready is high. The header check runs on a ten-byte
//   window (nine held bytes plus the incoming one) in the accept cycle.
//   Each result is registered into the FIFO at the edge that accepts its byte.
//   Results queue in a four-word output FIFO; in_ready drops while three or
//   more words wait, so a stalled receiver backs the input up after three
//   pending results without losing or repeating any word.
//   Reset clears all scan state, the FIFO and carrier_size. After a
//   completion or failure further bytes are taken and ignored until reset.
// ---------------------------------------------------------------------------
module record_chain_scanner #(
	parameter int MAX_MEMBERS       = 65536,
	parameter int MAX_TAG_PROBES    = 65536,
	parameter int MAX_CANDIDATES    = 64,
	parameter int MIN_CARRIER_BYTES = 82,
	parameter int OFFSET_BITS       = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        is_last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       record_kind,
	output logic [31:0]      header_offset,
	output logic [31:0]      packed_size,
	output logic [23:0]      unpacked_size,
	output logic [31:0]      chain_end,
	output logic [2:0]       error_code,
	output logic             run_end
);

	localparam int OB  = OFFSET_BITS;
	localparam int WB  = ((OB > 32) ? OB : 32) + 1;
	localparam int MW  = $clog2(MAX_MEMBERS + 1);
	localparam int PW  = $clog2(MAX_TAG_PROBES + 1);
	localparam int CW  = $clog2(MAX_CANDIDATES + 1);

	// scan state
	logic [31:0]   carrier_q;
	logic [7:0]    win_q [rcs_pkg::WIN_HIST];
	logic [OB-1:0] pos_q;
	logic          exe_ok_q;
	logic          chain_open_q;
	logic [OB-1:0] open_hdr_q;
	logic [23:0]   open_unp_q;
	logic [OB-1:0] chain_start_q;
	logic [OB-1:0] next_allowed_q;
	logic [MW-1:0] members_q;
	logic [PW-1:0] probes_q;
	logic [CW-1:0] cands_q;
	logic          done_q;

	// output FIFO
	rcs_pkg::result_t fifo_q [4];
	logic [1:0]       rd_ptr_q;
	logic [1:0]       wr_ptr_q;
	logic [2:0]       count_q;

	// byte evaluation
	logic [7:0]          w [10];
	logic                accept;
	logic                pop;
	logic [OB-1:0]       p;
	logic [WB-1:0]       p_ext;
	logic                judge;
	logic                tag_hit;
	rcs_pkg::hdr_kind_t  hkind;
	logic [31:0]         size_word;
	logic [WB-1:0]       packed_ext;
	logic [WB-1:0]       end_ext;
	logic [WB-1:0]       hdr_ext;
	logic [WB-1:0]       start_ext;
	logic [PW-1:0]       probes_inc;
	logic [CW-1:0]       cands_inc;
	logic [MW-1:0]       members_inc;

	logic                exe_ok_d;
	logic                chain_open_d;
	logic [OB-1:0]       open_hdr_d;
	logic [23:0]         open_unp_d;
	logic [OB-1:0]       chain_start_d;
	logic [OB-1:0]       next_allowed_d;
	logic [MW-1:0]       members_d;
	logic [PW-1:0]       probes_d;
	logic [CW-1:0]       cands_d;
	logic                done_d;
	rcs_pkg::result_t    r0;
	rcs_pkg::result_t    r1;
	logic [1:0]          n_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = (count_q <= 3'd2);
	assign accept    = in_valid & in_ready;
	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid & out_ready;

	always_comb begin
		for (int i = 0; i < rcs_pkg::WIN_HIST; i++) begin
			w[i] = win_q[i];
		end
		w[9] = byte_value;
	end

	// header judged at p = pos - 9
	assign p          = pos_q - OB'(9);
	assign p_ext      = WB'(p);
	assign judge      = exe_ok_q && (pos_q >= OB'(9)) && (pos_q != {OB{1'b1}})
		&& (p >= next_allowed_q) && ((p_ext + WB'(10)) <= WB'(carrier_q));
	assign tag_hit    = (w[0] == rcs_pkg::TAG_B0) && (w[1] == rcs_pkg::TAG_B1)
		&& (w[2] == rcs_pkg::TAG_B2) && (w[3] == rcs_pkg::TAG_B3);
	assign size_word  = {w[7], w[6], w[5], w[4]};
	assign hdr_ext    = WB'(open_hdr_q);
	assign start_ext  = WB'(chain_start_q);
	assign packed_ext = p_ext - (hdr_ext + WB'(8));
	assign end_ext    = p_ext + WB'(10);
	assign probes_inc  = probes_q + PW'(1);
	assign cands_inc   = cands_q + CW'(1);
	assign members_inc = members_q + MW'(1);

	// classify the window's trailing six bytes
	always_comb begin
		if ((w[4] == rcs_pkg::TAG_B0) && (w[5] == rcs_pkg::TAG_B1)
				&& (w[6] == rcs_pkg::TAG_B2) && (w[7] == rcs_pkg::TAG_B3)) begin
			hkind = ((w[8] == rcs_pkg::CHAR_CR) && (w[9] == rcs_pkg::CHAR_LF))
				? rcs_pkg::HDR_END : rcs_pkg::HDR_INVALID;
		end else if ((w[4] == rcs_pkg::NG_LO) && (w[5] == rcs_pkg::NG_HI)) begin
			hkind = rcs_pkg::HDR_INVALID;
		end else if ((size_word != 32'd0) && (size_word[31:24] == 8'd0)) begin
			hkind = rcs_pkg::HDR_MEMBER;
		end else begin
			hkind = rcs_pkg::HDR_INVALID;
		end
	end

	// per-byte scan step: next state and up to two results
	always_comb begin
		rcs_pkg::result_t fail_r;
		rcs_pkg::result_t last_r;

		fail_r                = '0;
		fail_r.kind           = rcs_pkg::KIND_FAILURE;
		last_r                = '0;
		exe_ok_d       = exe_ok_q;
		chain_open_d   = chain_open_q;
		open_hdr_d     = open_hdr_q;
		open_unp_d     = open_unp_q;
		chain_start_d  = chain_start_q;
		next_allowed_d = next_allowed_q;
		members_d      = members_q;
		probes_d       = probes_q;
		cands_d        = cands_q;
		done_d         = done_q;
		r0             = '0;
		r1             = '0;
		n_res          = 2'd0;

		if (!done_q) begin
			if (pos_q == OB'(0)) begin
				if (carrier_q < 32'(MIN_CARRIER_BYTES)) begin
					r0            = fail_r;
					r0.error_code = rcs_pkg::ERR_TOO_SMALL;
					n_res         = 2'd1;
					done_d        = 1'b1;
				end
			end else if (pos_q == OB'(1)) begin
				if ((w[8] == rcs_pkg::CHAR_M) && (w[9] == rcs_pkg::CHAR_Z)) begin
					exe_ok_d = 1'b1;
				end else begin
					r0            = fail_r;
					r0.error_code = rcs_pkg::ERR_NOT_EXE;
					n_res         = 2'd1;
					done_d        = 1'b1;
				end
			end else if (judge && tag_hit) begin
				if (hkind == rcs_pkg::HDR_INVALID) begin
					probes_d = probes_inc;
					if (probes_inc >= PW'(MAX_TAG_PROBES)) begin
						r0            = fail_r;
						r0.error_code = rcs_pkg::ERR_PROBES;
						n_res         = 2'd1;
						done_d        = 1'b1;
					end
				end else if (!chain_open_q) begin
					if (hkind == rcs_pkg::HDR_END) begin
						// early end record: failed candidate, resume one byte on
						cands_d        = cands_inc;
						probes_d       = '0;
						next_allowed_d = p + OB'(1);
						if (cands_inc >= CW'(MAX_CANDIDATES)) begin
							r0            = fail_r;
							r0.error_code = rcs_pkg::ERR_CANDIDATES;
							n_res         = 2'd1;
							done_d        = 1'b1;
						end
					end else begin
						chain_open_d   = 1'b1;
						chain_start_d  = p;
						members_d      = '0;
						open_hdr_d     = p;
						open_unp_d     = size_word[23:0];
						next_allowed_d = p + OB'(9);
						probes_d       = '0;
					end
				end else begin
					// close the open member
					r0.kind          = rcs_pkg::KIND_MEMBER;
					r0.header_offset = hdr_ext[31:0];
					r0.packed_size   = packed_ext[31:0];
					r0.unpacked_size = open_unp_q;
					n_res            = 2'd1;
					members_d        = members_inc;
					if (members_inc >= MW'(MAX_MEMBERS)) begin
						r1            = fail_r;
						r1.error_code = rcs_pkg::ERR_MEMBERS;
						n_res         = 2'd2;
						done_d        = 1'b1;
					end else if (hkind == rcs_pkg::HDR_END) begin
						r1.kind          = rcs_pkg::KIND_COMPLETE;
						r1.header_offset = start_ext[31:0];
						r1.chain_end     = end_ext[31:0];
						n_res            = 2'd2;
						done_d           = 1'b1;
					end else begin
						open_hdr_d     = p;
						open_unp_d     = size_word[23:0];
						next_allowed_d = p + OB'(9);
						probes_d       = '0;
					end
				end
			end

			// input ends without a completed chain
			if (!done_d && is_last_byte) begin
				last_r            = fail_r;
				last_r.error_code = exe_ok_d ? rcs_pkg::ERR_NO_CHAIN : rcs_pkg::ERR_NOT_EXE;
				done_d            = 1'b1;
				if (n_res == 2'd0) begin
					r0    = last_r;
					n_res = 2'd1;
				end else begin
					r1    = last_r;
					n_res = 2'd2;
				end
			end

			if (n_res == 2'd1) begin
				r0.run_end = 1'b1;
			end else if (n_res == 2'd2) begin
				r1.run_end = 1'b1;
			end
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			carrier_q <= cfg_data;
		end
	end

	// scan state: advance on every accepted byte until the scan is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcs_pkg::WIN_HIST; i++) begin
				win_q[i] <= '0;
			end
			pos_q          <= '0;
			exe_ok_q       <= 1'b0;
			chain_open_q   <= 1'b0;
			open_hdr_q     <= '0;
			open_unp_q     <= '0;
			chain_start_q  <= '0;
			next_allowed_q <= OB'(2);
			members_q      <= '0;
			probes_q       <= '0;
			cands_q        <= '0;
			done_q         <= 1'b0;
		end else if (accept && !done_q) begin
			for (int i = 0; i < rcs_pkg::WIN_HIST; i++) begin
				win_q[i] <= w[i+1];
			end
			if (pos_q != {OB{1'b1}}) begin
				pos_q <= pos_q + OB'(1);
			end
			exe_ok_q       <= exe_ok_d;
			chain_open_q   <= chain_open_d;
			open_hdr_q     <= open_hdr_d;
			open_unp_q     <= open_unp_d;
			chain_start_q  <= chain_start_d;
			next_allowed_q <= next_allowed_d;
			members_q      <= members_d;
			probes_q       <= probes_d;
			cands_q        <= cands_d;
			done_q         <= done_d;
		end
	end

	// output FIFO: push up to two words, pop one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			count_q <= count_q + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (n_res != 2'd0)) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (accept && (n_res == 2'd2)) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	assign record_kind   = fifo_q[rd_ptr_q].kind;
	assign header_offset = fifo_q[rd_ptr_q].header_offset;
	assign packed_size   = fifo_q[rd_ptr_q].packed_size;
	assign unpacked_size = fifo_q[rd_ptr_q].unpacked_size;
	assign chain_end     = fifo_q[rd_ptr_q].chain_end;
	assign error_code    = fifo_q[rd_ptr_q].error_code;
	assign run_end       = fifo_q[rd_ptr_q].run_end;

endmodule
`default_nettype wire

// ----- test/tb_record_chain_scanner.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_record_chain_scanner
// Self-checking bench for the record chain scanner. A small tracker class
// mirrors the scan state byte by byte and queues the member, completion and
// failure words that each accepted byte must produce. The bench streams one
// carrier: a directed opening with bad headers, early end records and dense
// members, then random header and filler traffic across several carrier
// sizes, and ends the carrier with a completion or a last-byte failure.
// Both channels see random idle bursts except during the closing stretch.
// ---------------------------------------------------------------------------
module tb_record_chain_scanner;

	localparam int MAX_MEMBERS       = 65536;
	localparam int MAX_TAG_PROBES    = 65536;
	localparam int MAX_CANDIDATES    = 64;
	localparam int MIN_CARRIER_BYTES = 82;
	localparam int OFFSET_BITS       = 32;

	localparam logic [31:0] POS_SATURATED = '1;
	localparam logic [31:0] SIZE_CEILING  = 32'h0100_0000;

	// stream plan, in carrier bytes sent
	localparam int NARROW_AT   = 700;
	localparam int ZERO_AT     = 900;
	localparam int WIDE_AT     = 1050;
	localparam int QUIET_AT    = 1650;
	localparam int ITEM_TARGET = 1900;

	localparam time TIMEOUT_NS = 4_000_000;

	// -----------------------------------------------------------------------
	// Scan tracker: mirrors the scanner and holds the words still owed
	// -----------------------------------------------------------------------
	class chain_tracker;
		logic [31:0] carrier_size;
		logic [7:0]  window [10];
		logic [31:0] position;
		logic        mz_seen;
		logic        chain_open;
		logic        scan_over;
		logic [31:0] member_hdr;
		logic [23:0] member_unpacked;
		logic [31:0] chain_first;
		logic [31:0] next_allowed;
		logic [16:0] member_count;
		logic [16:0] probe_count;
		logic [6:0]  candidate_count;
		rcs_pkg::result_t pending_records [$];
		int          mismatch_count;

		function new();
			int i;
			for (i = 0; i < 10; i++) window[i] = 8'h00;
			carrier_size    = '0;
			position        = '0;
			mz_seen         = 1'b0;
			chain_open      = 1'b0;
			scan_over       = 1'b0;
			member_hdr      = '0;
			member_unpacked = '0;
			chain_first     = '0;
			next_allowed    = 32'd2;
			member_count    = '0;
			probe_count     = '0;
			candidate_count = '0;
			mismatch_count  = 0;
		endfunction

		function void set_carrier_size(logic [31:0] value);
			carrier_size = value;
		endfunction

		function logic tag_at(int i);
			return window[i] == rcs_pkg::TAG_B0 && window[i + 1] == rcs_pkg::TAG_B1 &&
				window[i + 2] == rcs_pkg::TAG_B2 && window[i + 3] == rcs_pkg::TAG_B3;
		endfunction

		// judge the ten-byte window as a header starting at its oldest byte
		function rcs_pkg::hdr_kind_t classify(output logic [23:0] size);
			logic [31:0] value;
			size = '0;
			if (tag_at(4))
				return (window[8] == rcs_pkg::CHAR_CR && window[9] == rcs_pkg::CHAR_LF)
					? rcs_pkg::HDR_END : rcs_pkg::HDR_INVALID;
			if (window[4] == rcs_pkg::NG_LO && window[5] == rcs_pkg::NG_HI)
				return rcs_pkg::HDR_INVALID;
			value = {window[7], window[6], window[5], window[4]};
			if (value == 32'd0 || value >= SIZE_CEILING)
				return rcs_pkg::HDR_INVALID;
			size = value[23:0];
			return rcs_pkg::HDR_MEMBER;
		endfunction

		function void queue_record(logic [1:0] kind, logic [31:0] hdr, logic [31:0] span,
			logic [23:0] unpacked, logic [31:0] end_off, logic [2:0] err);
			rcs_pkg::result_t rec;
			rec.kind          = kind;
			rec.header_offset = hdr;
			rec.packed_size   = span;
			rec.unpacked_size = unpacked;
			rec.chain_end     = end_off;
			rec.error_code    = err;
			rec.run_end       = 1'b0;
			pending_records.push_back(rec);
		endfunction

		function void abort_scan(logic [2:0] err);
			scan_over = 1'b1;
			queue_record(rcs_pkg::KIND_FAILURE, '0, '0, '0, '0, err);
		endfunction

		function void open_member(logic [31:0] p, logic [23:0] size);
			member_hdr      = p;
			member_unpacked = size;
			next_allowed    = p + 32'd9;
			probe_count     = '0;
		endfunction

		// note one accepted carrier byte and queue what it causes
		function void take_byte(logic [7:0] value, logic is_last);
			logic [31:0]        pos;
			logic [31:0]        p;
			logic [23:0]        size;
			rcs_pkg::hdr_kind_t kind;
			rcs_pkg::result_t   tail;
			int                 queued;
			int                 i;
			if (scan_over) return;
			queued = pending_records.size();
			pos = position;
			for (i = 0; i < 9; i++) window[i] = window[i + 1];
			window[9] = value;
			if (position != POS_SATURATED) position++;

			if (pos == 32'd0) begin
				if (carrier_size < MIN_CARRIER_BYTES) abort_scan(rcs_pkg::ERR_TOO_SMALL);
			end else if (pos == 32'd1) begin
				if (window[8] == rcs_pkg::CHAR_M && window[9] == rcs_pkg::CHAR_Z)
					mz_seen = 1'b1;
				else
					abort_scan(rcs_pkg::ERR_NOT_EXE);
			end else if (mz_seen && pos >= 32'd9 && pos != POS_SATURATED) begin
				p = pos - 32'd9;
				if (p >= next_allowed && ({1'b0, p} + 33'd10) <= {1'b0, carrier_size} &&
					tag_at(0)) begin
					kind = classify(size);
					if (kind == rcs_pkg::HDR_INVALID) begin
						probe_count++;
						if (probe_count >= MAX_TAG_PROBES) abort_scan(rcs_pkg::ERR_PROBES);
					end else if (!chain_open) begin
						if (kind == rcs_pkg::HDR_END) begin
							candidate_count++;
							probe_count  = '0;
							next_allowed = p + 32'd1;
							if (candidate_count >= MAX_CANDIDATES)
								abort_scan(rcs_pkg::ERR_CANDIDATES);
						end else begin
							chain_open   = 1'b1;
							chain_first  = p;
							member_count = '0;
							open_member(p, size);
						end
					end else begin
						queue_record(rcs_pkg::KIND_MEMBER, member_hdr,
							p - (member_hdr + 32'd8), member_unpacked, '0,
							rcs_pkg::ERR_NONE);
						member_count++;
						if (member_count >= MAX_MEMBERS) begin
							abort_scan(rcs_pkg::ERR_MEMBERS);
						end else if (kind == rcs_pkg::HDR_END) begin
							scan_over = 1'b1;
							queue_record(rcs_pkg::KIND_COMPLETE, chain_first, '0, '0,
								p + 32'd10, rcs_pkg::ERR_NONE);
						end else begin
							open_member(p, size);
						end
					end
				end
			end

			if (!scan_over && is_last)
				abort_scan(mz_seen ? rcs_pkg::ERR_NO_CHAIN : rcs_pkg::ERR_NOT_EXE);

			if (pending_records.size() > queued) begin
				tail = pending_records.pop_back();
				tail.run_end = 1'b1;
				pending_records.push_back(tail);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		// compare one accepted result word with the oldest one owed
		function void match_record(rcs_pkg::result_t got);
			rcs_pkg::result_t want;
			if (pending_records.size() == 0) begin
				$error("record_kind: expected no word, actual %0d", got.kind);
				mismatch_count++;
				return;
			end
			want = pending_records.pop_front();
			check_field("record_kind", want.kind, got.kind);
			check_field("header_offset", want.header_offset, got.header_offset);
			check_field("packed_size", want.packed_size, got.packed_size);
			check_field("unpacked_size", want.unpacked_size, got.unpacked_size);
			check_field("chain_end", want.chain_end, got.chain_end);
			check_field("error_code", want.error_code, got.error_code);
			check_field("run_end", want.run_end, got.run_end);
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Signals and the block
	// -----------------------------------------------------------------------
	logic        clk;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value   = '0;
	logic        is_last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  record_kind;
	logic [31:0] header_offset;
	logic [31:0] packed_size;
	logic [23:0] unpacked_size;
	logic [31:0] chain_end;
	logic [2:0]  error_code;
	logic        run_end;

	chain_tracker tracker = new();

	int unsigned bytes_sent = 0;
	int unsigned stall_left = 0;
	logic        idle_on    = 1'b1;
	logic        quiet      = 1'b0;

	record_chain_scanner #(
		.MAX_MEMBERS       (MAX_MEMBERS),
		.MAX_TAG_PROBES    (MAX_TAG_PROBES),
		.MAX_CANDIDATES    (MAX_CANDIDATES),
		.MIN_CARRIER_BYTES (MIN_CARRIER_BYTES),
		.OFFSET_BITS       (OFFSET_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.is_last_byte  (is_last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.record_kind   (record_kind),
		.header_offset (header_offset),
		.packed_size   (packed_size),
		.unpacked_size (unpacked_size),
		.chain_end     (chain_end),
		.error_code    (error_code),
		.run_end       (run_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a word never shows up
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// Drop ready in random bursts; hold it high when quiet.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && !quiet && $urandom_range(0, 6) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check every result word at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_record({record_kind, header_offset, packed_size, unpacked_size,
				chain_end, error_code, run_end});
	end

	// -----------------------------------------------------------------------
	// Drivers
	// -----------------------------------------------------------------------

	// Offer one carrier byte; hold it until accepted, then note it.
	task automatic send_byte(input logic [7:0] value, input logic last);
		if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		byte_value   <= value;
		is_last_byte <= last;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(value, last);
		bytes_sent++;
	endtask

	// Write carrier_size; only called while the scanner is idle.
	task automatic set_carrier_size(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_carrier_size(value);
	endtask

	// Stop sending and wait until every owed word has left, plus a margin.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_records.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Filler leans on tag letters and CR/LF so partial headers show up often.
	function automatic logic [7:0] filler_byte();
		case ($urandom_range(0, 9))
			0:       return rcs_pkg::TAG_B0;
			1:       return rcs_pkg::TAG_B1;
			2:       return rcs_pkg::TAG_B2;
			3:       return rcs_pkg::TAG_B3;
			4:       return rcs_pkg::CHAR_CR;
			5:       return rcs_pkg::CHAR_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_filler(input int unsigned count);
		repeat (count) send_byte(filler_byte(), 1'b0);
	endtask

	task automatic send_tag();
		send_byte(rcs_pkg::TAG_B0, 1'b0);
		send_byte(rcs_pkg::TAG_B1, 1'b0);
		send_byte(rcs_pkg::TAG_B2, 1'b0);
		send_byte(rcs_pkg::TAG_B3, 1'b0);
	endtask

	// tag plus little-endian size word
	task automatic send_header(input logic [31:0] size);
		send_tag();
		send_byte(size[7:0], 1'b0);
		send_byte(size[15:8], 1'b0);
		send_byte(size[23:16], 1'b0);
		send_byte(size[31:24], 1'b0);
	endtask

	task automatic send_end_record(input logic last);
		send_tag();
		send_tag();
		send_byte(rcs_pkg::CHAR_CR, 1'b0);
		send_byte(rcs_pkg::CHAR_LF, last);
	endtask

	function automatic logic [31:0] random_member_size();
		case ($urandom_range(0, 5))
			0:       return 32'd1;
			1:       return 32'h00FF_FFFF;
			2:       return $urandom_range(1, 255);
			default: return $urandom_range(1, 32'h00FF_FFFF);
		endcase
	endfunction

	// a tag followed by something that is not a valid header
	task automatic send_broken_header();
		logic [31:0] noise;
		noise = $urandom;
		case ($urandom_range(0, 3))
			0: send_header(32'd0);
			1: send_header({noise[31:16], rcs_pkg::NG_HI, rcs_pkg::NG_LO});
			2: send_header({noise[31:24] | 8'h01, noise[23:0]});
			default: begin
				// double tag with a damaged CR/LF pair
				send_tag();
				send_tag();
				if (noise[0]) begin
					send_byte(rcs_pkg::CHAR_CR, 1'b0);
					send_byte(noise[15:8] == rcs_pkg::CHAR_LF ? 8'h00 : noise[15:8], 1'b0);
				end else begin
					send_byte(noise[15:8] == rcs_pkg::CHAR_CR ? 8'h00 : noise[15:8], 1'b0);
					send_byte(rcs_pkg::CHAR_LF, 1'b0);
				end
			end
		endcase
	endtask

	task automatic send_random_segment();
		int unsigned pick;
		idle_on = ($urandom_range(0, 4) != 0);
		quiet   = (bytes_sent >= QUIET_AT);
		pick    = $urandom_range(0, 99);
		if (pick < 50) begin
			send_header(random_member_size());
			send_filler($urandom_range(0, 14));
		end else if (pick < 70) begin
			send_filler($urandom_range(1, 20));
		end else if (pick < 85) begin
			send_broken_header();
		end else begin
			// headers packed right against each other, some inside the
			// nine-byte exclusion of the one before
			send_header(random_member_size());
			send_filler($urandom_range(0, 2));
			send_header(random_member_size());
		end
	endtask

	// Close the carrier one of three ways, then feed bytes the scanner ignores.
	task automatic finish_carrier();
		case ($urandom_range(0, 2))
			0: begin
				send_filler($urandom_range(0, 10));
				send_end_record(1'($urandom_range(0, 1)));
			end
			1: begin
				// member closes on the very byte that ends the input
				send_filler(2);
				send_header(random_member_size());
				send_byte(filler_byte(), 1'b0);
				send_byte(filler_byte(), 1'b1);
			end
			default: begin
				send_filler(3);
				send_byte(filler_byte(), 1'b1);
			end
		endcase
		repeat ($urandom_range(2, 6)) send_byte(filler_byte(), 1'b0);
		send_byte(filler_byte(), 1'b1);
	endtask

	// -----------------------------------------------------------------------
	// Sequence
	// -----------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest carrier: every header position counts
		set_carrier_size(32'hFFFF_FFFF);

		// directed opening: executable mark, byte extremes
		send_byte(rcs_pkg::CHAR_M, 1'b0);
		send_byte(rcs_pkg::CHAR_Z, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// rejected probes before any chain: zero size, NG word, size at the
		// ceiling, double tag without CR/LF
		send_header(32'd0);
		send_header(32'h0012_474E);
		send_header(SIZE_CEILING);
		send_tag();
		send_tag();
		send_byte(rcs_pkg::CHAR_CR, 1'b0);
		send_byte(8'h00, 1'b0);
		// early end records count as failed candidates
		send_end_record(1'b0);
		send_end_record(1'b0);
		// smallest member opens the chain; the next header is too close
		send_header(32'd1);
		send_header(32'h0012_3456);
		send_filler(1);
		// largest size, then a low byte that looks like NG but is not
		send_header(32'h00FF_FFFF);
		send_filler(4);
		send_header(32'h0001_004E);
		send_filler(9);
		// rejected probe inside the open chain
		send_header(32'd0);
		send_filler(2);
		send_header(32'h0000_00FF);

		// hold the sender until every owed word is out
		settle();

		while (bytes_sent < NARROW_AT) send_random_segment();

		// carrier ends a little past the current position: later headers drop
		settle();
		set_carrier_size(tracker.position + $urandom_range(20, 120));
		while (bytes_sent < ZERO_AT) send_random_segment();

		// empty carrier: no header counts at all
		settle();
		set_carrier_size(32'd0);
		while (bytes_sent < WIDE_AT) send_random_segment();

		// back to a large carrier for the rest of the stream
		settle();
		set_carrier_size($urandom_range(32'h0001_0000, 32'hFFFF_FFFE));
		while (bytes_sent < ITEM_TARGET) send_random_segment();

		quiet = 1'b1;
		finish_carrier();

		settle();
		repeat (16) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
